### src/bpa_pkg.sv
package bpa_pkg;

   // sequencer states
   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_A_START,
      ST_T_FIND,
      ST_T_RDF,
      ST_T_SPLIT,
      ST_T_STORE,
      ST_A_CHK,
      ST_A_RDC,
      ST_A_GOTC,
      ST_F_RD,
      ST_F_CHK,
      ST_F_HI,
      ST_D_LOOP,
      ST_D_GOT,
      ST_G_TEST,
      ST_G_CHK,
      ST_G_UNL1,
      ST_G_UNL2,
      ST_G_PUSH,
      ST_RMW_RD,
      ST_RMW_WR,
      ST_DONE
   } state_type;

   // request commands
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // response status
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_OOM = 1'b1;

   // configuration register indexes
   localparam logic REG_BATCH = 1'b0;
   localparam logic REG_HIGH  = 1'b1;

   localparam logic [8:0] BATCH_RESET = 9'd63;
   localparam logic [8:0] HIGH_RESET  = 9'd378;

   // frame marks
   localparam logic [1:0] MARK_BUDDY = 2'd0;
   localparam logic [1:0] MARK_CACHE = 2'd1;
   localparam logic [1:0] MARK_USED  = 2'd2;
   localparam logic [1:0] MARK_NONE  = 2'd3;

   // field select for read-modify-write of a frame entry
   localparam logic [3:0] FLD_ORDER = 4'b0001;
   localparam logic [3:0] FLD_MARK  = 4'b0010;
   localparam logic [3:0] FLD_NEXT  = 4'b0100;
   localparam logic [3:0] FLD_PREV  = 4'b1000;

endpackage

### src/bpa_cfg.sv
module bpa_cfg import bpa_pkg::*; #(
   parameter int CACHE_DEPTH = 512
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic [8:0]                     csr_data,
   output logic [$clog2(CACHE_DEPTH):0]   eff_high,
   output logic [$clog2(CACHE_DEPTH):0]   eff_batch
);

   localparam int CNW = $clog2(CACHE_DEPTH) + 1;
   localparam int HW  = (CNW > 9) ? CNW : 9;

   logic [8:0]    batch_ff, batch_in;
   logic [8:0]    high_ff, high_in;
   logic [HW-1:0] hm, bm, h, b;

   // register writes
   always_comb begin
      batch_in = batch_ff;
      high_in  = high_ff;
      if (csr_we) begin
         case (csr_index)
            REG_BATCH: batch_in = csr_data;
            REG_HIGH:  high_in  = csr_data;
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_ff <= BATCH_RESET;
         high_ff  <= HIGH_RESET;
      end else begin
         batch_ff <= batch_in;
         high_ff  <= high_in;
      end
   end

   // clamp high to [2, depth], batch to [1, high]
   always_comb begin
      hm = HW'(high_ff);
      bm = HW'(batch_ff);
      if (hm < HW'(2)) begin
         h = HW'(2);
      end else if (hm > HW'(CACHE_DEPTH)) begin
         h = HW'(CACHE_DEPTH);
      end else begin
         h = hm;
      end
      if (bm == '0) begin
         b = HW'(1);
      end else if (bm > h) begin
         b = h;
      end else begin
         b = bm;
      end
   end

   assign eff_high  = CNW'(h);
   assign eff_batch = CNW'(b);

endmodule

### src/buddy_page_allocator_percpu_top.sv
// Page frame allocator: binary buddy lists behind one page cache per cpu.
// Request channel (req_valid/req_stall): req_cmd allocates or frees one
// frame for cpu req_cpu; req_frame names the frame to free.
// Response channel (rsp_valid/rsp_stall): exactly one transaction per
// request, rsp_page with rsp_status (out of memory on a failed allocate).
// Configuration (csr_we/csr_index/csr_data) sets batch size and high mark,
// to be written only while the block is idle; the block does not enforce this.
// After reset the frame table memory is initialized, one entry a cycle,
// all NUM_FRAMES entries, with req_stall high; all top-order blocks start free.
// req_stall drops in the same cycle that a response appears, so the next
// request can be taken then. A refill or drain walks batch frames one at a
// time through the frame table, which has one read and one write port.
// One request is worked on at a time. A finished response waits in the
// output register while the next request is taken; if the receiver stalls,
// that request holds in its final state until the output register frees.
module buddy_page_allocator_percpu_top import bpa_pkg::*; #(
   parameter int NUM_FRAMES  = 65536,
   parameter int NUM_ORDERS  = 11,
   parameter int NUM_CPUS    = 16,
   parameter int CACHE_DEPTH = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [3:0]  req_cpu,
   input  logic [15:0] req_frame,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_page,
   output logic        rsp_status,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [8:0]  csr_data
);

   localparam int FW   = $clog2(NUM_FRAMES);
   localparam int LW   = FW + 1;
   localparam int OW   = $clog2(NUM_ORDERS);
   localparam int TOP  = NUM_ORDERS - 1;
   localparam int DW   = $clog2(CACHE_DEPTH);
   localparam int CNW  = DW + 1;
   localparam int SW   = DW + 2;
   localparam int CPW  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int CSN  = NUM_CPUS * CACHE_DEPTH;
   localparam int CAW  = $clog2(CSN);
   localparam int BLK  = 1 << TOP;
   localparam int NBLK = NUM_FRAMES / BLK;
   localparam int BEND = NBLK * BLK;
   localparam logic [LW-1:0] NIL = LW'(NUM_FRAMES);

   typedef struct packed {
      logic [OW-1:0] order;
      logic [1:0]    mark;
      logic [LW-1:0] nxt;
      logic [LW-1:0] prv;
   } fent_type;

   // frame table and cache ring memories
   fent_type      fmem [NUM_FRAMES];
   fent_type      fm_rd_ff;
   logic          fm_we;
   logic [FW-1:0] fm_waddr, fm_raddr;
   fent_type      fm_wdata;

   logic [FW-1:0]  cmem [CSN];
   logic [FW-1:0]  cs_rd_ff;
   logic           cs_we;
   logic [CAW-1:0] cs_waddr, cs_raddr;
   logic [FW-1:0]  cs_wdata;

   // control and working registers
   state_type      state_ff, state_in, ret_ff, ret_in;
   logic [FW-1:0]  init_ff, init_in;
   logic [CPW-1:0] cpu_ff, cpu_in;
   logic [15:0]    frame_ff, frame_in;
   logic [LW-1:0]  f_ff, f_in, b_ff, b_in, n_ff, n_in, p_ff, p_in;
   logic [OW-1:0]  k_ff, k_in;
   logic [CNW-1:0] iter_ff, iter_in, bn_ff, bn_in;
   logic [FW-1:0]  rmw_addr_ff, rmw_addr_in;
   logic [3:0]     rmw_mask_ff, rmw_mask_in;
   logic [LW-1:0]  rmw_val_ff, rmw_val_in;
   logic [15:0]    res_page_ff, res_page_in;
   logic           res_status_ff, res_status_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [15:0]    rsp_page_ff, rsp_page_in;
   logic           rsp_status_ff, rsp_status_in;
   logic [LW-1:0]  head_ff [NUM_ORDERS];
   logic [LW-1:0]  head_in [NUM_ORDERS];
   logic [DW-1:0]  front_ff [NUM_CPUS];
   logic [DW-1:0]  front_in [NUM_CPUS];
   logic [CNW-1:0] count_ff [NUM_CPUS];
   logic [CNW-1:0] count_in [NUM_CPUS];

   logic [CNW-1:0] eff_high, eff_batch;

   bpa_cfg #(.CACHE_DEPTH(CACHE_DEPTH)) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .eff_high  (eff_high),
      .eff_batch (eff_batch)
   );

   function automatic logic [CPW-1:0] cpu_map(input logic [3:0] c);
      logic [CPW-1:0] r;
      r = '0;
      for (int i = 0; i < 16; i++) begin
         if (c == 4'(i)) r = CPW'(i % NUM_CPUS);
      end
      return r;
   endfunction

   function automatic logic [DW-1:0] ring_wrap(input logic [SW-1:0] s);
      if (s >= SW'(CACHE_DEPTH)) return DW'(s - SW'(CACHE_DEPTH));
      return DW'(s);
   endfunction

   function automatic fent_type init_entry(input logic [FW-1:0] idx);
      fent_type e;
      logic [31:0] i;
      logic        hd;
      i  = 32'(idx);
      hd = ((i % BLK) == 0) && (i < 32'(BEND));
      e.order = hd ? OW'(TOP) : '0;
      e.mark  = (i < 32'(BEND)) ? MARK_BUDDY : MARK_NONE;
      e.nxt   = (hd && (i + 32'(BLK) < 32'(BEND))) ? LW'(i + 32'(BLK)) : NIL;
      e.prv   = (hd && (i > 0)) ? LW'(i - 32'(BLK)) : NIL;
      return e;
   endfunction

   // current cpu view
   logic [DW-1:0]  cur_front, tail_idx, last_idx, next_front, prev_front;
   logic [CNW-1:0] cur_count;
   logic [CAW-1:0] cbase;
   logic [SW-1:0]  tsum;
   assign cur_front  = front_ff[cpu_ff];
   assign cur_count  = count_ff[cpu_ff];
   assign tsum       = SW'(cur_front) + SW'(cur_count);
   assign tail_idx   = ring_wrap(tsum);
   assign last_idx   = ring_wrap(tsum - SW'(1));
   assign next_front = ring_wrap(SW'(cur_front) + SW'(1));
   assign prev_front = (cur_front == '0) ? DW'(CACHE_DEPTH - 1) : cur_front - DW'(1);
   assign cbase      = CAW'(CAW'(cpu_ff) * CAW'(CACHE_DEPTH));

   // lowest order with a free block
   logic          found;
   logic [OW-1:0] fk;
   always_comb begin
      found = 1'b0;
      fk    = '0;
      for (int i = NUM_ORDERS - 1; i >= 0; i--) begin
         if (head_ff[i] != NIL) begin
            found = 1'b1;
            fk    = OW'(i);
         end
      end
   end

   // split and merge helpers
   logic [OW-1:0] kdn;
   logic [LW-1:0] half, bud;
   logic          frame_ok;
   fent_type      rmw_ent;
   assign kdn      = k_ff - OW'(1);
   assign half     = f_ff + (LW'(1) << kdn);
   assign bud      = f_ff ^ (LW'(1) << k_ff);
   assign frame_ok = 32'(frame_ff) < 32'(NUM_FRAMES);

   always_comb begin
      rmw_ent = fm_rd_ff;
      if (rmw_mask_ff[0]) rmw_ent.order = OW'(rmw_val_ff);
      if (rmw_mask_ff[1]) rmw_ent.mark  = 2'(rmw_val_ff);
      if (rmw_mask_ff[2]) rmw_ent.nxt   = rmw_val_ff;
      if (rmw_mask_ff[3]) rmw_ent.prv   = rmw_val_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         ST_INIT:    if (init_ff == FW'(NUM_FRAMES - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) state_in = (req_cmd == CMD_ALLOC) ? ST_A_START : ST_F_RD;
         end
         ST_A_START: state_in = (cur_count == '0) ? ST_T_FIND : ST_A_RDC;
         ST_T_FIND:  state_in = (iter_ff != bn_ff && found) ? ST_T_RDF : ST_A_CHK;
         ST_T_RDF: begin
            if (fm_rd_ff.nxt != NIL) begin
               state_in = ST_RMW_RD;
               ret_in   = ST_T_SPLIT;
            end else begin
               state_in = ST_T_SPLIT;
            end
         end
         ST_T_SPLIT: begin
            if (k_ff == '0) begin
               state_in = ST_T_STORE;
            end else if (head_ff[kdn] != NIL) begin
               state_in = ST_RMW_RD;
               ret_in   = ST_T_SPLIT;
            end
         end
         ST_T_STORE: state_in = ST_T_FIND;
         ST_A_CHK:   state_in = (cur_count == '0) ? ST_DONE : ST_A_RDC;
         ST_A_RDC:   state_in = ST_A_GOTC;
         ST_A_GOTC: begin
            state_in = ST_RMW_RD;
            ret_in   = ST_DONE;
         end
         ST_F_RD:    state_in = frame_ok ? ST_F_CHK : ST_DONE;
         ST_F_CHK: begin
            state_in = (fm_rd_ff.mark == MARK_USED && cur_count < CNW'(CACHE_DEPTH)) ?
                       ST_F_HI : ST_DONE;
         end
         ST_F_HI:    state_in = (cur_count >= eff_high) ? ST_D_LOOP : ST_DONE;
         ST_D_LOOP:  state_in = (iter_ff != bn_ff && cur_count != '0) ? ST_D_GOT : ST_DONE;
         ST_D_GOT:   state_in = ST_G_TEST;
         ST_G_TEST:  state_in = (k_ff != OW'(TOP) && bud < NIL) ? ST_G_CHK : ST_G_PUSH;
         ST_G_CHK: begin
            state_in = (fm_rd_ff.mark == MARK_BUDDY && fm_rd_ff.order == k_ff) ?
                       ST_G_UNL1 : ST_G_PUSH;
         end
         ST_G_UNL1: begin
            state_in = ST_G_UNL2;
            if (p_ff != NIL) begin
               state_in = ST_RMW_RD;
               ret_in   = ST_G_UNL2;
            end
         end
         ST_G_UNL2: begin
            state_in = ST_G_TEST;
            if (n_ff != NIL) begin
               state_in = ST_RMW_RD;
               ret_in   = ST_G_TEST;
            end
         end
         ST_G_PUSH: begin
            state_in = ST_D_LOOP;
            if (head_ff[k_ff] != NIL) begin
               state_in = ST_RMW_RD;
               ret_in   = ST_D_LOOP;
            end
         end
         ST_RMW_RD:  state_in = ST_RMW_WR;
         ST_RMW_WR:  state_in = ret_ff;
         ST_DONE:    if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      init_in       = init_ff;
      cpu_in        = cpu_ff;
      frame_in      = frame_ff;
      f_in          = f_ff;
      b_in          = b_ff;
      n_in          = n_ff;
      p_in          = p_ff;
      k_in          = k_ff;
      iter_in       = iter_ff;
      bn_in         = bn_ff;
      rmw_addr_in   = rmw_addr_ff;
      rmw_mask_in   = rmw_mask_ff;
      rmw_val_in    = rmw_val_ff;
      res_page_in   = res_page_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_status_in = rsp_status_ff;
      head_in       = head_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      fm_we         = 1'b0;
      fm_waddr      = rmw_addr_ff;
      fm_raddr      = rmw_addr_ff;
      fm_wdata      = rmw_ent;
      cs_we         = 1'b0;
      cs_waddr      = cbase + CAW'(tail_idx);
      cs_raddr      = cbase + CAW'(cur_front);
      cs_wdata      = FW'(f_ff);

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_INIT: begin
            fm_we    = 1'b1;
            fm_waddr = init_ff;
            fm_wdata = init_entry(init_ff);
            init_in  = init_ff + FW'(1);
         end
         ST_IDLE: begin
            if (req_valid) begin
               cpu_in   = cpu_map(req_cpu);
               frame_in = req_frame;
            end
         end
         ST_A_START: begin
            iter_in = '0;
            bn_in   = eff_batch;
         end
         ST_T_FIND: begin
            f_in     = head_ff[fk];
            k_in     = fk;
            fm_raddr = FW'(head_ff[fk]);
         end
         ST_T_RDF: begin
            // unlink list head, mark it cached
            fm_we          = 1'b1;
            fm_waddr       = FW'(f_ff);
            fm_wdata       = fm_rd_ff;
            fm_wdata.order = '0;
            fm_wdata.mark  = MARK_CACHE;
            head_in[k_ff]  = fm_rd_ff.nxt;
            rmw_addr_in    = FW'(fm_rd_ff.nxt);
            rmw_mask_in    = FLD_PREV;
            rmw_val_in     = NIL;
         end
         ST_T_SPLIT: begin
            // upper half goes onto the next lower list
            if (k_ff != '0) begin
               fm_we          = 1'b1;
               fm_waddr       = FW'(half);
               fm_wdata.order = kdn;
               fm_wdata.mark  = MARK_BUDDY;
               fm_wdata.nxt   = head_ff[kdn];
               fm_wdata.prv   = NIL;
               head_in[kdn]   = half;
               k_in           = kdn;
               rmw_addr_in    = FW'(head_ff[kdn]);
               rmw_mask_in    = FLD_PREV;
               rmw_val_in     = half;
            end
         end
         ST_T_STORE: begin
            cs_we            = 1'b1;
            count_in[cpu_ff] = cur_count + CNW'(1);
            iter_in          = iter_ff + CNW'(1);
         end
         ST_A_CHK: begin
            res_page_in   = '0;
            res_status_in = STATUS_OOM;
         end
         ST_A_RDC: ;
         ST_A_GOTC: begin
            front_in[cpu_ff] = next_front;
            count_in[cpu_ff] = cur_count - CNW'(1);
            res_page_in      = 16'(cs_rd_ff);
            res_status_in    = STATUS_OK;
            rmw_addr_in      = cs_rd_ff;
            rmw_mask_in      = FLD_MARK;
            rmw_val_in       = LW'(MARK_USED);
         end
         ST_F_RD: begin
            res_page_in   = frame_ff;
            res_status_in = STATUS_OK;
            fm_raddr      = FW'(frame_ff);
         end
         ST_F_CHK: begin
            if (fm_rd_ff.mark == MARK_USED) begin
               fm_we         = 1'b1;
               fm_waddr      = FW'(frame_ff);
               fm_wdata      = fm_rd_ff;
               fm_wdata.mark = MARK_CACHE;
               if (cur_count < CNW'(CACHE_DEPTH)) begin
                  front_in[cpu_ff] = prev_front;
                  count_in[cpu_ff] = cur_count + CNW'(1);
                  cs_we            = 1'b1;
                  cs_waddr         = cbase + CAW'(prev_front);
                  cs_wdata         = FW'(frame_ff);
               end
            end
         end
         ST_F_HI: begin
            iter_in = '0;
            bn_in   = eff_batch;
         end
         ST_D_LOOP: begin
            // pop from the cache back
            cs_raddr = cbase + CAW'(last_idx);
            if (iter_ff != bn_ff && cur_count != '0) begin
               count_in[cpu_ff] = cur_count - CNW'(1);
               iter_in          = iter_ff + CNW'(1);
            end
         end
         ST_D_GOT: begin
            f_in = LW'(cs_rd_ff);
            k_in = '0;
         end
         ST_G_TEST: begin
            b_in     = bud;
            fm_raddr = FW'(bud);
         end
         ST_G_CHK: begin
            // buddy free at same order: unlink and merge
            if (fm_rd_ff.mark == MARK_BUDDY && fm_rd_ff.order == k_ff) begin
               p_in = fm_rd_ff.prv;
               n_in = fm_rd_ff.nxt;
               if (fm_rd_ff.prv == NIL) head_in[k_ff] = fm_rd_ff.nxt;
               f_in = f_ff & b_ff;
               k_in = k_ff + OW'(1);
            end
         end
         ST_G_UNL1: begin
            rmw_addr_in = FW'(p_ff);
            rmw_mask_in = FLD_NEXT;
            rmw_val_in  = n_ff;
         end
         ST_G_UNL2: begin
            rmw_addr_in = FW'(n_ff);
            rmw_mask_in = FLD_PREV;
            rmw_val_in  = p_ff;
         end
         ST_G_PUSH: begin
            fm_we          = 1'b1;
            fm_waddr       = FW'(f_ff);
            fm_wdata.order = k_ff;
            fm_wdata.mark  = MARK_BUDDY;
            fm_wdata.nxt   = head_ff[k_ff];
            fm_wdata.prv   = NIL;
            head_in[k_ff]  = f_ff;
            rmw_addr_in    = FW'(head_ff[k_ff]);
            rmw_mask_in    = FLD_PREV;
            rmw_val_in     = f_ff;
         end
         ST_RMW_RD: ;
         ST_RMW_WR: begin
            fm_we = 1'b1;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_page_in   = res_page_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         ret_ff       <= ST_IDLE;
         init_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_ORDERS; i++) begin
            head_ff[i] <= (i == TOP && NBLK > 0) ? '0 : NIL;
         end
         for (int i = 0; i < NUM_CPUS; i++) begin
            front_ff[i] <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cpu_ff        <= cpu_in;
      frame_ff      <= frame_in;
      f_ff          <= f_in;
      b_ff          <= b_in;
      n_ff          <= n_in;
      p_ff          <= p_in;
      k_ff          <= k_in;
      iter_ff       <= iter_in;
      bn_ff         <= bn_in;
      rmw_addr_ff   <= rmw_addr_in;
      rmw_mask_ff   <= rmw_mask_in;
      rmw_val_ff    <= rmw_val_in;
      res_page_ff   <= res_page_in;
      res_status_ff <= res_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_status_ff <= rsp_status_in;
   end

   // frame table memory
   always_ff @(posedge clock) begin
      if (fm_we) fmem[fm_waddr] <= fm_wdata;
      fm_rd_ff <= fmem[fm_raddr];
   end

   // cpu cache ring memory
   always_ff @(posedge clock) begin
      if (cs_we) cmem[cs_waddr] <= cs_wdata;
      cs_rd_ff <= cmem[cs_raddr];
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_page   = rsp_page_ff;
   assign rsp_status = rsp_status_ff;

endmodule
